@@ src/cau_pkg.sv @@
`default_nettype none
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_NEG  = 4'd4,
    OP_CONJ = 4'd5,
    OP_MAG  = 4'd6,
    OP_EQ   = 4'd7,
    OP_NE   = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  // What the iterative stages do with a beat.
  typedef enum logic [1:0] {
    SEL_PASS = 2'd0,
    SEL_DIV  = 2'd1,
    SEL_SQRT = 2'd2
  } sel_t;

  typedef struct packed {
    sel_t sel;
    logic neg_re;
    logic neg_im;
    logic pre_ovf_re;
    logic pre_ovf_im;
    logic flag;
    logic div0;
  } ctrl_t;

endpackage
`default_nettype wire

@@ src/complex_arithmetic_unit.sv @@
// Throughput: one beat per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so a stall freezes every stage in place.
// Divide and magnitude run through DATA_WIDTH shared stages, one quotient/root bit each.
// Reset (rst, synchronous, active high) clears all valid bits; the data registers are not reset.
`default_nettype none
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [3:0]                   operation,
  input  wire logic signed [DATA_WIDTH-1:0] a_re,
  input  wire logic signed [DATA_WIDTH-1:0] a_im,
  input  wire logic signed [DATA_WIDTH-1:0] b_re,
  input  wire logic signed [DATA_WIDTH-1:0] b_im,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      res_re,
  output logic signed [DATA_WIDTH-1:0]      res_im,
  output logic                              compare_flag,
  output logic [1:0]                        status
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = 2 * DATA_WIDTH + 1;
  localparam int XW = 3 * DATA_WIDTH + FRAC_BITS;

  // Advance every stage together when the output slot is free or draining.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: operand capture and products ----------------
  logic signed [W-1:0] sq_re_in;
  logic signed [W-1:0] sq_im_in;
  assign sq_re_in = (op_t'(operation) == OP_MAG) ? a_re : b_re;
  assign sq_im_in = (op_t'(operation) == OP_MAG) ? a_im : b_im;

  logic                 v1;
  op_t                  op1;
  logic signed [W-1:0]  ar1, ai1, br1, bi1;
  logic signed [PW-1:0] p_rr1, p_ii1, p_ri1, p_ir1, d_r1, d_i1;
  logic                 eq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1   <= op_t'(operation);
      ar1   <= a_re;
      ai1   <= a_im;
      br1   <= b_re;
      bi1   <= b_im;
      p_rr1 <= PW'(a_re) * PW'(b_re);
      p_ii1 <= PW'(a_im) * PW'(b_im);
      p_ri1 <= PW'(a_re) * PW'(b_im);
      p_ir1 <= PW'(a_im) * PW'(b_re);
      d_r1  <= PW'(sq_re_in) * PW'(sq_re_in);
      d_i1  <= PW'(sq_im_in) * PW'(sq_im_in);
      eq1   <= (a_re == b_re) && (a_im == b_im);
    end
  end

  // ---------------- stage 2: signed sums per opcode ----------------
  logic signed [SW-1:0] val_re_next, val_im_next;
  logic                 flag_next;

  always_comb begin
    val_re_next = '0;
    val_im_next = '0;
    flag_next   = 1'b0;
    case (op1)
      OP_ADD: begin
        val_re_next = SW'(ar1) + SW'(br1);
        val_im_next = SW'(ai1) + SW'(bi1);
      end
      OP_SUB: begin
        val_re_next = SW'(ar1) - SW'(br1);
        val_im_next = SW'(ai1) - SW'(bi1);
      end
      OP_MUL: begin
        val_re_next = SW'(p_rr1) - SW'(p_ii1);
        val_im_next = SW'(p_ri1) + SW'(p_ir1);
      end
      OP_DIV: begin
        val_re_next = SW'(p_rr1) + SW'(p_ii1);
        val_im_next = SW'(p_ir1) - SW'(p_ri1);
      end
      OP_NEG: begin
        val_re_next = -SW'(ar1);
        val_im_next = -SW'(ai1);
      end
      OP_CONJ: begin
        val_re_next = SW'(ar1);
        val_im_next = -SW'(ai1);
      end
      OP_EQ:   flag_next = eq1;
      OP_NE:   flag_next = !eq1;
      default: ;
    endcase
  end

  logic                 v2;
  op_t                  op2;
  logic signed [SW-1:0] val_re2, val_im2;
  logic [PW-1:0]        den2;
  logic                 flag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2     <= op1;
      val_re2 <= val_re_next;
      val_im2 <= val_im_next;
      den2    <= PW'(d_r1) + PW'(d_i1);
      flag2   <= flag_next;
    end
  end

  // ---------------- stage 3: sign-magnitude and routing ----------------
  logic [PW-1:0] mag_re, mag_im;
  logic [XW-1:0] num_re_next, num_im_next;
  ctrl_t         ctrl_next;

  always_comb begin
    mag_re = val_re2[SW-1] ? PW'(-val_re2) : PW'(val_re2);
    mag_im = val_im2[SW-1] ? PW'(-val_im2) : PW'(val_im2);
    ctrl_next            = '0;
    ctrl_next.neg_re     = val_re2[SW-1];
    ctrl_next.neg_im     = val_im2[SW-1];
    ctrl_next.flag       = flag2;
    ctrl_next.sel        = SEL_PASS;
    num_re_next          = XW'(mag_re);
    num_im_next          = XW'(mag_im);
    case (op2)
      OP_MUL: begin
        num_re_next = XW'(mag_re >> FRAC_BITS);
        num_im_next = XW'(mag_im >> FRAC_BITS);
      end
      OP_DIV: begin
        ctrl_next.sel        = SEL_DIV;
        ctrl_next.div0       = (den2 == '0);
        num_re_next          = XW'(mag_re) << FRAC_BITS;
        num_im_next          = XW'(mag_im) << FRAC_BITS;
        // Quotient wider than DATA_WIDTH bits: saturate regardless.
        ctrl_next.pre_ovf_re = num_re_next >= (XW'(den2) << W);
        ctrl_next.pre_ovf_im = num_im_next >= (XW'(den2) << W);
      end
      OP_MAG: begin
        ctrl_next.sel    = SEL_SQRT;
        ctrl_next.neg_re = 1'b0;
        num_re_next      = XW'(den2);
      end
      default: ;
    endcase
  end

  logic          v3;
  ctrl_t         ctrl3;
  logic [XW-1:0] num_re3, num_im3;
  logic [PW-1:0] den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl3   <= ctrl_next;
      num_re3 <= num_re_next;
      num_im3 <= num_im_next;
      den3    <= den2;
    end
  end

  // ---------------- bit-serial divide / square root stages ----------------
  logic          vc;
  ctrl_t         ctrlc;
  logic [XW-1:0] rem_rec, rem_imc;
  logic [W-1:0]  q_rec, q_imc;

  cau_core_pipe #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (v3),
    .in_ctrl    (ctrl3),
    .in_rem_re  (num_re3),
    .in_rem_im  (num_im3),
    .in_den     (den3),
    .out_valid  (vc),
    .out_ctrl   (ctrlc),
    .out_rem_re (rem_rec),
    .out_rem_im (rem_imc),
    .out_q_re   (q_rec),
    .out_q_im   (q_imc)
  );

  // ---------------- output stage: saturate and register ----------------
  localparam logic [XW-1:0] LIM_POS = XW'({1'b0, {(W-1){1'b1}}});
  localparam logic [XW-1:0] LIM_NEG = XW'({1'b1, {(W-1){1'b0}}});

  logic [XW-1:0] fin_re, fin_im, sat_re, sat_im;
  logic          ovf_re, ovf_im;
  logic [W-1:0]  res_re_next, res_im_next;
  logic [1:0]    status_next;

  always_comb begin
    fin_re = (ctrlc.sel == SEL_PASS) ? rem_rec : XW'(q_rec);
    fin_im = (ctrlc.sel == SEL_PASS) ? rem_imc : XW'(q_imc);
    ovf_re = ctrlc.pre_ovf_re || (fin_re > (ctrlc.neg_re ? LIM_NEG : LIM_POS));
    ovf_im = ctrlc.pre_ovf_im || (fin_im > (ctrlc.neg_im ? LIM_NEG : LIM_POS));
    sat_re = ovf_re ? (ctrlc.neg_re ? LIM_NEG : LIM_POS) : fin_re;
    sat_im = ovf_im ? (ctrlc.neg_im ? LIM_NEG : LIM_POS) : fin_im;
    res_re_next = ctrlc.neg_re ? -sat_re[W-1:0] : sat_re[W-1:0];
    res_im_next = ctrlc.neg_im ? -sat_im[W-1:0] : sat_im[W-1:0];
    status_next = (ovf_re || ovf_im) ? ST_OVF : ST_OK;
    // Zero divisor: drop the quotient, report it instead.
    if (ctrlc.div0) begin
      res_re_next = '0;
      res_im_next = '0;
      status_next = ST_DIV0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re       <= res_re_next;
      res_im       <= res_im_next;
      compare_flag <= ctrlc.flag;
      status       <= status_next;
    end
  end

  // ---------------- checks ----------------
  a_div0_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DIV0) |-> (res_re == '0) && (res_im == '0))
    else $error("divide by zero with nonzero result");

  a_flag_clean : assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_flag |-> (res_re == '0) && (res_im == '0) && (status == ST_OK))
    else $error("comparison beat carries arithmetic result");

  a_ovf_limit : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OVF) |->
      (res_re == W'(LIM_POS)) || (res_re == W'(LIM_NEG)) ||
      (res_im == W'(LIM_POS)) || (res_im == W'(LIM_NEG)))
    else $error("overflow reported without a saturated part");

endmodule
`default_nettype wire

@@ src/cau_core_pipe.sv @@
`default_nettype none
module cau_core_pipe
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire ctrl_t                         in_ctrl,
  input  wire logic [3*DATA_WIDTH+FRAC_BITS-1:0] in_rem_re,
  input  wire logic [3*DATA_WIDTH+FRAC_BITS-1:0] in_rem_im,
  input  wire logic [2*DATA_WIDTH-1:0]       in_den,
  output logic                               out_valid,
  output ctrl_t                              out_ctrl,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0]  out_rem_re,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0]  out_rem_im,
  output logic [DATA_WIDTH-1:0]              out_q_re,
  output logic [DATA_WIDTH-1:0]              out_q_im
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int XW = 3 * DATA_WIDTH + FRAC_BITS;

  logic          v_st      [W];
  ctrl_t         ctrl_st   [W];
  logic [XW-1:0] rem_re_st [W];
  logic [XW-1:0] rem_im_st [W];
  logic [W-1:0]  q_re_st   [W];
  logic [W-1:0]  q_im_st   [W];
  // The last stage passes no divisor on.
  logic [PW-1:0] den_st    [W-1];

  // One quotient or root bit per stage, most significant first.
  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int I = W - 1 - k;
    logic          p_v;
    ctrl_t         p_ctrl;
    logic [XW-1:0] p_rem_re;
    logic [XW-1:0] p_rem_im;
    logic [W-1:0]  p_q_re;
    logic [W-1:0]  p_q_im;
    logic [PW-1:0] p_den;
    logic [XW-1:0] d_sh;
    logic [XW-1:0] t_sq;
    logic [XW-1:0] sub_re;
    logic          take_re;
    logic          take_im;

    if (k == 0) begin : g_first
      assign p_v      = in_valid;
      assign p_ctrl   = in_ctrl;
      assign p_rem_re = in_rem_re;
      assign p_rem_im = in_rem_im;
      assign p_q_re   = '0;
      assign p_q_im   = '0;
      assign p_den    = in_den;
    end else begin : g_next
      assign p_v      = v_st[k-1];
      assign p_ctrl   = ctrl_st[k-1];
      assign p_rem_re = rem_re_st[k-1];
      assign p_rem_im = rem_im_st[k-1];
      assign p_q_re   = q_re_st[k-1];
      assign p_q_im   = q_im_st[k-1];
      assign p_den    = den_st[k-1];
    end

    always_comb begin
      d_sh    = XW'(p_den) << I;
      t_sq    = (XW'(p_q_re) << (I + 1)) + ({{(XW-1){1'b0}}, 1'b1} << (2 * I));
      sub_re  = (p_ctrl.sel == SEL_SQRT) ? t_sq : d_sh;
      take_re = (p_ctrl.sel != SEL_PASS) && (p_rem_re >= sub_re);
      take_im = (p_ctrl.sel == SEL_DIV) && (p_rem_im >= d_sh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_st[k] <= 1'b0;
      end else if (adv) begin
        v_st[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctrl_st[k]   <= p_ctrl;
        rem_re_st[k] <= take_re ? p_rem_re - sub_re : p_rem_re;
        rem_im_st[k] <= take_im ? p_rem_im - d_sh : p_rem_im;
        q_re_st[k]   <= take_re ? (p_q_re | (W'(1) << I)) : p_q_re;
        q_im_st[k]   <= take_im ? (p_q_im | (W'(1) << I)) : p_q_im;
      end
    end

    if (k < W - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (adv) begin
          den_st[k] <= p_den;
        end
      end
    end
  end

  assign out_valid  = v_st[W-1];
  assign out_ctrl   = ctrl_st[W-1];
  assign out_rem_re = rem_re_st[W-1];
  assign out_rem_im = rem_im_st[W-1];
  assign out_q_re   = q_re_st[W-1];
  assign out_q_im   = q_im_st[W-1];

endmodule
`default_nettype wire
